// File: rtl/timed_lift_level_sequencer_assert.svh
// ---------------------------------------------------------------------------
// Timed lift level sequencer assertion macros
// Shared concurrent check forms for the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef TIMED_LIFT_LEVEL_SEQUENCER_ASSERT_SVH
`define TIMED_LIFT_LEVEL_SEQUENCER_ASSERT_SVH

// same-cycle implication, held off during reset
`define TLLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlls assertion failed");

// next-cycle implication, held off during reset
`define TLLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlls assertion failed");

`endif

// File: rtl/tlls_pkg.sv
// ---------------------------------------------------------------------------
// tlls_pkg
// Types, codes and constants of the timed lift level sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package tlls_pkg;

	localparam int NUM_LEVELS = 5;
	localparam int LEVEL_W    = 3;
	localparam int SEG_W      = 16;
	localparam int NUM_SEGS   = 4;
	localparam int TIME_W     = 32;
	localparam int DUR_W      = SEG_W + 2;
	localparam int CFG_IDX_W  = 4;

	localparam logic [LEVEL_W-1:0] TOP_LEVEL =
		LEVEL_W'((NUM_LEVELS - 1 > 7) ? 7 : NUM_LEVELS - 1);

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_UP_FIRST   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_UP_LAST    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FIRST = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LAST  = CFG_IDX_W'(7);

	// drive codes
	localparam logic [1:0] DRIVE_HOLD    = 2'd0;
	localparam logic [1:0] DRIVE_UP      = 2'd1;
	localparam logic [1:0] DRIVE_DOWN    = 2'd2;
	localparam logic [1:0] DRIVE_RELEASE = 2'd3;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef logic [NUM_SEGS-1:0][SEG_W-1:0] seg_times_t;

	localparam seg_times_t SEG_RESET = {16'd735, 16'd590, 16'd400, 16'd250};

	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic [LEVEL_W-1:0] requested_level;
		logic               enabled;
	} item_t;

	typedef struct packed {
		logic [1:0]         drive;
		logic               busy_res;
		logic [LEVEL_W-1:0] level_estimate;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] executed_target;
		logic [LEVEL_W-1:0] estimated_level;
		logic [LEVEL_W-1:0] active_target;
		logic [LEVEL_W-1:0] pending_target;
		logic               pending_valid;
		logic               moving;
		dir_t               direction;
		logic [TIME_W-1:0]  move_end_time;
	} seq_state_t;

endpackage

`default_nettype wire

// File: rtl/tlls_cfg_regs.sv
// ---------------------------------------------------------------------------
// tlls_cfg_regs
// Up and down segment time registers with a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module tlls_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tlls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tlls_pkg::SEG_W-1:0]     cfg_data,
	output tlls_pkg::seg_times_t                up_time,
	output tlls_pkg::seg_times_t                down_time
);
	import tlls_pkg::*;

	seg_times_t up_q;
	seg_times_t down_q;

	// indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= SEG_RESET;
			down_q <= SEG_RESET;
		end else if (cfg_we) begin
			case (cfg_index) inside
				[CFG_UP_FIRST:CFG_UP_LAST]: begin
					up_q[cfg_index[1:0]] <= cfg_data;
				end
				[CFG_DOWN_FIRST:CFG_DOWN_LAST]: begin
					down_q[cfg_index[1:0]] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign up_time   = up_q;
	assign down_time = down_q;

endmodule

`default_nettype wire

// File: rtl/tlls_step.sv
// ---------------------------------------------------------------------------
// tlls_step
// Per-item next-state and result logic of the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module tlls_step (
	input  wire tlls_pkg::item_t      item,
	input  wire tlls_pkg::seq_state_t cur,
	input  wire tlls_pkg::seg_times_t up_time,
	input  wire tlls_pkg::seg_times_t down_time,
	output tlls_pkg::seq_state_t      nxt,
	output tlls_pkg::result_t         result
);
	import tlls_pkg::*;

	logic [LEVEL_W-1:0] req;
	logic [LEVEL_W-1:0] tgt;
	logic [LEVEL_W-1:0] lo;
	logic [LEVEL_W-1:0] hi;
	logic               rising;
	logic               start;
	seg_times_t         segs;
	logic [DUR_W-1:0]   dur;
	logic [TIME_W-1:0]  diff;
	logic               started_move;
	seq_state_t         mid;

	assign req = (item.requested_level > TOP_LEVEL) ? TOP_LEVEL : item.requested_level;

	// target selection when idle: held request first, new request otherwise; while moving, a differing request is held
	always_comb begin
		mid = cur;
		if (cur.moving) begin
			if (req != cur.active_target) begin
				mid.pending_target = req;
				mid.pending_valid  = 1'b1;
			end
		end else if (cur.pending_valid) begin
			mid.active_target = cur.pending_target;
			mid.pending_valid = 1'b0;
		end else begin
			mid.active_target = req;
		end
	end

	assign tgt    = mid.active_target;
	assign start  = (tgt != cur.executed_target);
	assign rising = (tgt > cur.estimated_level);
	assign lo     = rising ? cur.estimated_level : tgt;
	assign hi     = rising ? tgt : cur.estimated_level;
	assign segs   = rising ? up_time : down_time;

	// segment i spans level i and i+1; levels above 4 have no segments
	always_comb begin
		dur = '0;
		for (int i = 0; i < NUM_SEGS; i++) begin
			if ((lo <= LEVEL_W'(i)) && (LEVEL_W'(i) < hi)) begin
				dur = dur + DUR_W'(segs[i[1:0]]);
			end
		end
	end

	assign diff = cur.move_end_time - item.now_ms;

	always_comb begin
		nxt          = mid;
		started_move = 1'b0;
		result.drive = DRIVE_HOLD;
		if (!item.enabled) begin
			nxt = cur;
		end else begin
			if (start) begin
				if (tgt != cur.estimated_level) begin
					nxt.direction = rising ? DIR_UP : DIR_DOWN;
					nxt.moving    = (dur != '0);
				end else begin
					nxt.direction = DIR_NONE;
					nxt.moving    = 1'b0;
				end
				started_move        = nxt.moving;
				if (nxt.moving) begin
					nxt.move_end_time = item.now_ms + TIME_W'(dur);
				end
				nxt.executed_target = tgt;
			end
			// a move just started has a positive span and cannot end here
			if (nxt.moving) begin
				if (!started_move && ((diff == '0) || diff[TIME_W-1])) begin
					nxt.moving          = 1'b0;
					nxt.estimated_level = nxt.executed_target;
					nxt.direction       = DIR_NONE;
				end else begin
					case (nxt.direction)
						DIR_UP:   result.drive = DRIVE_UP;
						DIR_DOWN: result.drive = DRIVE_DOWN;
						default:  result.drive = DRIVE_HOLD;
					endcase
				end
			end
		end
		if (!item.enabled) begin
			result.drive = DRIVE_RELEASE;
		end
		result.busy_res       = item.enabled & nxt.moving;
		result.level_estimate = nxt.estimated_level;
	end

endmodule

`default_nettype wire

// File: rtl/timed_lift_level_sequencer.sv
// ---------------------------------------------------------------------------
// timed_lift_level_sequencer
// Open-loop lift level sequencer timed from a millisecond clock.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req) carries one control tick: time,
//    requested level and enable. res channel returns one result per tick:
//    drive code, busy flag and the level estimate.
//  - A transfer on req lands in the input stage; the edge that moves it on
//    computes the result and updates the sequencer state together, so the
//    result register and the state register load at the same edge.
//  - Throughput is one tick per cycle while res_ready is high. The state loop
//    (target pick, a four-entry masked segment sum, end-time add and wrap
//    compare) is combinational; back-to-back ticks see each other's effects.
//  - When res_ready is low the result register holds; the input stage still
//    takes one more tick, after which req_ready drops until res drains.
//  - The user writes segment times through cfg_we/cfg_index/cfg_data only
//    while the block is idle; the block does not enforce it. Bad indexes are ignored.
//  - arst_n clears the sequencer state to level 0, not moving, and loads the
//    default segment times; both stages come up empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "timed_lift_level_sequencer_assert.svh"

module timed_lift_level_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire tlls_pkg::item_t                req,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output tlls_pkg::result_t                   res,
	input  wire logic                           cfg_we,
	input  wire logic [tlls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tlls_pkg::SEG_W-1:0]     cfg_data
);
	import tlls_pkg::*;

	seg_times_t up_time;
	seg_times_t down_time;

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    res_s2;
	seq_state_t st_q;
	seq_state_t st_nxt;
	result_t    step_res;
	logic       advance;

	tlls_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.up_time   (up_time),
		.down_time (down_time)
	);

	tlls_step u_step (
		.item      (item_s1),
		.cur       (st_q),
		.up_time   (up_time),
		.down_time (down_time),
		.nxt       (st_nxt),
		.result    (step_res)
	);

	// tick moves into the result register when that slot is free or draining
	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '{default: '0, direction: DIR_NONE};
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nxt;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// a running move always has a direction
	`TLLS_ASSERT_IMP(a_move_has_dir, clk, arst_n, st_q.moving, st_q.direction != DIR_NONE)
	// busy results drive the motor up or down
	`TLLS_ASSERT_IMP(a_busy_drives, clk, arst_n, res_valid && res.busy_res,
		(res.drive == DRIVE_UP) || (res.drive == DRIVE_DOWN))
	// a disabled tick releases the drive
	`TLLS_ASSERT_NXT(a_disabled_release, clk, arst_n, advance && !item_s1.enabled,
		res.drive == DRIVE_RELEASE && !res.busy_res)
	// the estimate never leaves the level range
	`TLLS_ASSERT_IMP(a_level_range, clk, arst_n, 1'b1,
		(st_q.estimated_level <= TOP_LEVEL) && (st_q.active_target <= TOP_LEVEL))

endmodule

`default_nettype wire
